// ===== design/rmth_pkg.sv =====
// Shared constants, types and control structs for the running median core.
`timescale 1ns / 1ps

package rmth_pkg;

   localparam int HALF_DEPTH = 512;
   localparam int IDX_W      = $clog2(HALF_DEPTH);
   localparam int SIZE_W     = $clog2(HALF_DEPTH + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MEDIAN_W   = 33;
   localparam int COUNT_W    = 11;

   // Per-cycle operation applied to one sorted chain.
   typedef enum logic [1:0] {
      CHAIN_HOLD    = 2'd0,
      CHAIN_INSERT  = 2'd1,
      CHAIN_REPLACE = 2'd2
   } chain_op_type;

   // Broadcast control shared by every cell of a chain.
   typedef struct packed {
      chain_op_type               op;
      logic signed [SAMPLE_W-1:0] key;
      logic [SIZE_W-1:0]          size;
      logic                       is_max;
   } chain_ctl_type;

endpackage

// ===== design/rmth_cell.sv =====
// One sorted-chain cell: holds a value and shifts toward or away from its neighbors.
`timescale 1ns / 1ps

module rmth_cell (
   input  logic                                clock,
   input  logic [rmth_pkg::IDX_W-1:0]          cell_index,
   input  rmth_pkg::chain_ctl_type             ctl,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0] left_value,
   input  logic                                left_flag,
   input  logic signed [rmth_pkg::SAMPLE_W-1:0] right_value,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] cell_value,
   output logic                                cell_flag
);
   import rmth_pkg::*;

   logic signed [SAMPLE_W-1:0] value_ff;
   logic signed [SAMPLE_W-1:0] value_in;
   logic signed [SAMPLE_W-1:0] cmp_value;
   logic [SIZE_W-1:0]          index_ext;
   logic                       occupied;
   logic                       key_above;
   logic                       stay;

   assign index_ext = SIZE_W'(cell_index);

   // Replace compares against the element that moves up into this slot.
   always_comb begin
      if (ctl.op == CHAIN_REPLACE) begin
         cmp_value = right_value;
         occupied  = (index_ext + SIZE_W'(1)) < ctl.size;
      end else begin
         cmp_value = value_ff;
         occupied  = index_ext < ctl.size;
      end
      key_above = ctl.is_max ? (ctl.key > cmp_value) : (ctl.key < cmp_value);
      stay      = occupied && !key_above;
   end

   assign cell_flag = stay;

   always_comb begin
      case (ctl.op)
         CHAIN_INSERT: begin
            if (stay)           value_in = value_ff;
            else if (left_flag) value_in = ctl.key;
            else                value_in = left_value;
         end
         CHAIN_REPLACE: begin
            if (stay)           value_in = right_value;
            else if (left_flag) value_in = ctl.key;
            else                value_in = value_ff;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

// ===== design/rmth_chain.sv =====
// Row of sorted cells holding one half; the top element sits in cell zero.
`timescale 1ns / 1ps

module rmth_chain (
   input  logic                                 clock,
   input  rmth_pkg::chain_ctl_type              ctl,
   output logic signed [rmth_pkg::SAMPLE_W-1:0] top_value
);
   import rmth_pkg::*;

   logic signed [SAMPLE_W-1:0] value_w [HALF_DEPTH];
   logic                       flag_w  [HALF_DEPTH];

   for (genvar k = 0; k < HALF_DEPTH; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] left_v;
      logic                       left_f;
      logic signed [SAMPLE_W-1:0] right_v;

      if (k == 0) begin : g_first
         assign left_v = ctl.key;
         assign left_f = 1'b1;
      end else begin : g_inner
         assign left_v = value_w[k-1];
         assign left_f = flag_w[k-1];
      end

      if (k == HALF_DEPTH - 1) begin : g_last
         assign right_v = value_w[k];
      end else begin : g_mid
         assign right_v = value_w[k+1];
      end

      rmth_cell u_cell (
         .clock       (clock),
         .cell_index  (IDX_W'(k)),
         .ctl         (ctl),
         .left_value  (left_v),
         .left_flag   (left_f),
         .right_value (right_v),
         .cell_value  (value_w[k]),
         .cell_flag   (flag_w[k])
      );
   end

   assign top_value = value_w[0];

endmodule

// ===== design/running_median_two_heaps_core.sv =====
// Top level of the running median core: sequencer, two sorted halves and result register.
`timescale 1ns / 1ps

// Running median of a signed 32-bit stream. Each request beat carries one
// sample (tdata) and a restart flag (tuser) that empties both halves first.
// Samples are kept in two rows of HALF_DEPTH cells: the lower half sorted
// largest first, the upper half smallest first, so both tops are always in
// cell zero. Insertion is a broadcast: every cell compares the new value
// with its own and either holds or shifts one place, and a move across
// halves pops one row and inserts in the other in the same cycle. An item
// is registered, then the chains update, then the result is formed from
// the new tops and registered. Beats are taken only in the idle state, so
// a new sample waits until the previous one has been through these steps.
// A new beat is taken while the previous result still waits on rsp_tready;
// the last step then holds until that result leaves. The response beat
// carries twice the median (33 bits, one fractional bit), the count held
// and, in tuser, a drop flag raised when both halves are full; then nothing
// changes and the previous median is repeated. No clearing pass is needed
// after reset.
module running_median_two_heaps_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [32:0] median_doubled, [43:33] sample_count, zero pad
   output logic        rsp_tuser    // [0] dropped
);
   import rmth_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_OP   = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       restart_ff;
   logic [SIZE_W-1:0]          lower_size_ff, lower_size_in;
   logic [SIZE_W-1:0]          upper_size_ff, upper_size_in;
   logic signed [MEDIAN_W-1:0] median_ff, median_in;
   logic                       dropped_ff, dropped_in;
   logic                       rsp_valid_ff;
   logic [MEDIAN_W-1:0]        rsp_median_ff;
   logic [COUNT_W-1:0]         rsp_count_ff;
   logic                       rsp_dropped_ff;

   chain_ctl_type              lower_ctl, upper_ctl;
   logic signed [SAMPLE_W-1:0] lower_top, upper_top;

   logic [SIZE_W-1:0]          ls_eff, us_eff;
   logic signed [MEDIAN_W:0]   sample_x2;
   logic signed [MEDIAN_W:0]   median_ext;
   logic                       below_median, above_median;
   logic                       store_full;
   logic                       out_free;
   logic signed [MEDIAN_W-1:0] new_median;

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Decision on the registered sample, using sizes after an optional restart.
   assign ls_eff       = restart_ff ? '0 : lower_size_ff;
   assign us_eff       = restart_ff ? '0 : upper_size_ff;
   assign sample_x2    = {sample_ff[SAMPLE_W-1], sample_ff, 1'b0};
   assign median_ext   = {median_ff[MEDIAN_W-1], median_ff};
   assign below_median = sample_x2 < median_ext;
   assign above_median = sample_x2 > median_ext;
   assign store_full   = (ls_eff == SIZE_W'(HALF_DEPTH)) && (us_eff == SIZE_W'(HALF_DEPTH));

   always_comb begin
      lower_ctl.op     = CHAIN_HOLD;
      lower_ctl.key    = sample_ff;
      lower_ctl.size   = ls_eff;
      lower_ctl.is_max = 1'b1;
      upper_ctl.op     = CHAIN_HOLD;
      upper_ctl.key    = sample_ff;
      upper_ctl.size   = us_eff;
      upper_ctl.is_max = 1'b0;
      lower_size_in    = lower_size_ff;
      upper_size_in    = upper_size_ff;
      dropped_in       = dropped_ff;
      if (state_ff == ST_OP) begin
         lower_size_in = ls_eff;
         upper_size_in = us_eff;
         dropped_in    = 1'b0;
         if (store_full) begin
            dropped_in = 1'b1;
         end else if (ls_eff == '0 && us_eff == '0) begin
            lower_ctl.op  = CHAIN_INSERT;
            lower_size_in = ls_eff + SIZE_W'(1);
         end else if (ls_eff > us_eff) begin
            if (below_median) begin
               // Move the lower top across, then put the sample in its place.
               upper_ctl.op  = CHAIN_INSERT;
               upper_ctl.key = lower_top;
               lower_ctl.op  = CHAIN_REPLACE;
               upper_size_in = us_eff + SIZE_W'(1);
            end else begin
               upper_ctl.op  = CHAIN_INSERT;
               upper_size_in = us_eff + SIZE_W'(1);
            end
         end else if (ls_eff == us_eff) begin
            if (below_median) begin
               lower_ctl.op  = CHAIN_INSERT;
               lower_size_in = ls_eff + SIZE_W'(1);
            end else begin
               upper_ctl.op  = CHAIN_INSERT;
               upper_size_in = us_eff + SIZE_W'(1);
            end
         end else begin
            if (above_median) begin
               lower_ctl.op  = CHAIN_INSERT;
               lower_ctl.key = upper_top;
               upper_ctl.op  = CHAIN_REPLACE;
               lower_size_in = ls_eff + SIZE_W'(1);
            end else begin
               lower_ctl.op  = CHAIN_INSERT;
               lower_size_in = ls_eff + SIZE_W'(1);
            end
         end
      end
   end

   rmth_chain u_lower (
      .clock     (clock),
      .ctl       (lower_ctl),
      .top_value (lower_top)
   );

   rmth_chain u_upper (
      .clock     (clock),
      .ctl       (upper_ctl),
      .top_value (upper_top)
   );

   // Median from the updated tops: twice the larger half's top, or the sum.
   always_comb begin
      if (lower_size_ff > upper_size_ff) begin
         new_median = {lower_top, 1'b0};
      end else if (upper_size_ff > lower_size_ff) begin
         new_median = {upper_top, 1'b0};
      end else begin
         new_median = {lower_top[SAMPLE_W-1], lower_top}
                    + {upper_top[SAMPLE_W-1], upper_top};
      end
   end

   always_comb begin
      state_in  = state_ff;
      median_in = median_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_OP;
         end
         ST_OP: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (!dropped_ff) median_in = new_median;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lower_size_ff <= '0;
         upper_size_ff <= '0;
         median_ff     <= '0;
         dropped_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lower_size_ff <= lower_size_in;
         upper_size_ff <= upper_size_in;
         median_ff     <= median_in;
         dropped_ff    <= dropped_in;
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: capture the request beat, load the result beat.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff  <= req_tdata;
         restart_ff <= req_tuser;
      end
      if (state_ff == ST_FIN && out_free) begin
         rsp_median_ff  <= median_in;
         rsp_count_ff   <= COUNT_W'({1'b0, lower_size_ff} + {1'b0, upper_size_ff});
         rsp_dropped_ff <= dropped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_count_ff, rsp_median_ff};
   assign rsp_tuser  = rsp_dropped_ff;

   // Halves never drift apart by more than one.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, lower_size_ff} <= {1'b0, upper_size_ff} + 1'b1) &&
      ({1'b0, upper_size_ff} <= {1'b0, lower_size_ff} + 1'b1))
      else $error("half sizes differ by more than one");

   // Neither half overflows its row of cells.
   assert property (@(posedge clock) disable iff (reset)
      (lower_size_ff <= SIZE_W'(HALF_DEPTH)) && (upper_size_ff <= SIZE_W'(HALF_DEPTH)))
      else $error("half size beyond depth");

   // Every lower element stays at or below every upper element.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && lower_size_ff != '0 && upper_size_ff != '0)
      |-> (lower_top <= upper_top))
      else $error("lower top above upper top");

   // With balanced halves the held median is the sum of the tops.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && lower_size_ff == upper_size_ff && lower_size_ff != '0)
      |-> (median_ff == {lower_top[SAMPLE_W-1], lower_top}
                      + {upper_top[SAMPLE_W-1], upper_top}))
      else $error("held median disagrees with tops");

endmodule

// ===== tb/tb_running_median_two_heaps_core.sv =====
// Self-checking testbench for the running median core: directed table and random runs.
`timescale 1ns / 1ps

module tb_running_median_two_heaps_core;
   import rmth_pkg::*;

   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 528;
   localparam int LONG_HOLD    = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 500000;

   // How a run of random samples is spread over the signed range.
   typedef enum int {
      SPREAD_FULL   = 0,
      SPREAD_NARROW = 1,
      SPREAD_EDGE   = 2,
      SPREAD_MID    = 3
   } spread_type;

   // One request beat plus, for pinned rows, the result typed in by hand.
   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                restart;
      bit                  pinned;
      logic [MEDIAN_W-1:0] med;
      logic [COUNT_W-1:0]  cnt;
      logic                drop;
   } beat_row_type;

   typedef struct packed {
      logic [MEDIAN_W-1:0] median_x2;
      logic [COUNT_W-1:0]  count;
      logic                dropped;
   } median_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] sample
   logic        req_tuser;   // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // [32:0] median_doubled, [43:33] sample_count, zero pad
   logic        rsp_tuser;   // [0] dropped

   // Predictor state: lower half kept largest first, upper half smallest first.
   int     lower_vals[$];
   int     upper_vals[$];
   longint median_x2_now;

   beat_row_type      directed_rows[$];
   beat_row_type      offered_rows[$];
   median_result_type pending_medians[$];

   int unsigned mismatch_count;
   int unsigned beats_sent;
   int unsigned restarts_sent;
   int unsigned medians_checked;
   int unsigned drops_seen;
   int unsigned peak_count;
   int unsigned burst_left;
   bit          hold_rsp;

   running_median_two_heaps_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Median predictor
   // ---------------------------------------------------------------------

   function automatic void lower_push(input int v);
      int i;
      i = 0;
      while (i < lower_vals.size() && lower_vals[i] > v) i++;
      lower_vals.insert(i, v);
   endfunction

   function automatic void upper_push(input int v);
      int i;
      i = 0;
      while (i < upper_vals.size() && upper_vals[i] < v) i++;
      upper_vals.insert(i, v);
   endfunction

   // Insert one sample and return the doubled median, the count held and the drop flag.
   function automatic median_result_type track_median(input logic [SAMPLE_W-1:0] smp,
                                                      input logic rst);
      median_result_type r;
      int                x;
      longint            x2;
      x  = smp;
      x2 = 2 * longint'(x);
      r.dropped = 1'b0;
      if (rst) begin
         lower_vals.delete();
         upper_vals.delete();
      end
      if (lower_vals.size() >= HALF_DEPTH && upper_vals.size() >= HALF_DEPTH) begin
         // store full: discard, keep the old median
         r.dropped = 1'b1;
      end else if (lower_vals.size() == 0 && upper_vals.size() == 0) begin
         lower_push(x);
         median_x2_now = x2;
      end else if (lower_vals.size() > upper_vals.size()) begin
         // lower side heavy: a low sample pushes the lower top across
         if (x2 < median_x2_now) begin
            upper_push(lower_vals.pop_front());
            lower_push(x);
         end else begin
            upper_push(x);
         end
         median_x2_now = longint'(lower_vals[0]) + longint'(upper_vals[0]);
      end else if (lower_vals.size() == upper_vals.size()) begin
         // balanced: a tie with the median goes up
         if (x2 < median_x2_now) begin
            lower_push(x);
            median_x2_now = 2 * longint'(lower_vals[0]);
         end else begin
            upper_push(x);
            median_x2_now = 2 * longint'(upper_vals[0]);
         end
      end else begin
         // upper side heavy: a high sample pushes the upper top across
         if (x2 > median_x2_now) begin
            lower_push(upper_vals.pop_front());
            upper_push(x);
         end else begin
            lower_push(x);
         end
         median_x2_now = longint'(lower_vals[0]) + longint'(upper_vals[0]);
      end
      r.median_x2 = median_x2_now[MEDIAN_W-1:0];
      r.count     = COUNT_W'(lower_vals.size() + upper_vals.size());
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic beat_row_type make_row(input logic [SAMPLE_W-1:0] smp, input logic rst);
      beat_row_type row;
      row.sample  = smp;
      row.restart = rst;
      row.pinned  = 1'b0;
      row.med     = '0;
      row.cnt     = '0;
      row.drop    = 1'b0;
      return row;
   endfunction

   function automatic beat_row_type pinned_row(input logic [SAMPLE_W-1:0] smp,
                                               input logic rst,
                                               input logic [MEDIAN_W-1:0] med,
                                               input logic [COUNT_W-1:0] cnt,
                                               input logic drop);
      beat_row_type row;
      row        = make_row(smp, rst);
      row.pinned = 1'b1;
      row.med    = med;
      row.cnt    = cnt;
      row.drop   = drop;
      return row;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(input beat_row_type row);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample(input spread_type spread);
      logic [SAMPLE_W-1:0] v;
      v = $urandom();
      // mix in a fully random value now and then whatever the spread
      if ($urandom_range(0, 9) != 0) begin
         case (spread)
            SPREAD_NARROW: v = $urandom_range(0, 16) - 32'd8;
            SPREAD_MID:    v = $urandom_range(0, 2000) - 32'd1000;
            SPREAD_EDGE: begin
               case ($urandom_range(0, 3))
                  0:       v = 32'h8000_0000;
                  1:       v = 32'h7FFF_FFFF;
                  2:       v = 32'h8000_0000 + $urandom_range(0, 3);
                  default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
               endcase
            end
            default: v = $urandom();
         endcase
      end
      return v;
   endfunction

   // Mostly short gaps, a few long ones.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int unsigned pick_pass();
      if ($urandom_range(0, 9) == 0) return $urandom_range(30, 80);
      return $urandom_range(1, 8);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("MISMATCH at result %0d, %s: got %h, expected %h",
               medians_checked, what, got, want);
   endtask

   // Offer one beat after an optional gap and hold it until accepted.
   task automatic send_beat(input beat_row_type row);
      int unsigned gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered_rows.insert(offered_rows.size(), row);
      req_tvalid <= 1'b1;
      req_tdata  <= row.sample;
      req_tuser  <= row.restart;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      beats_sent++;
      if (row.restart) restarts_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Sender: reset, directed table, random runs, drain
   // ---------------------------------------------------------------------

   initial begin : req_side
      int unsigned sent_random;
      int unsigned run_left;
      spread_type  spread;
      logic        first;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      mismatch_count = 0;
      beats_sent     = 0;
      restarts_sent  = 0;
      medians_checked = 0;
      drops_seen     = 0;
      peak_count     = 0;
      burst_left     = 0;
      hold_rsp       = 1'b0;
      median_x2_now  = 0;

      // First sample after reset, extremes of the range, ties with the median in
      // every balance state, and restarts in the middle of a run.
      add_row(pinned_row(32'd5, 1'b0, 33'd10, 11'd1, 1'b0));
      add_row(make_row(32'd5, 1'b0));
      add_row(pinned_row(32'h8000_0000, 1'b1, 33'h1_0000_0000, 11'd1, 1'b0));
      add_row(pinned_row(32'h7FFF_FFFF, 1'b0, 33'h1_FFFF_FFFF, 11'd2, 1'b0));
      add_row(pinned_row(32'h7FFF_FFFF, 1'b1, 33'h0_FFFF_FFFE, 11'd1, 1'b0));
      add_row(pinned_row(32'h8000_0000, 1'b0, 33'h1_FFFF_FFFF, 11'd2, 1'b0));
      add_row(make_row(32'd0, 1'b0));
      add_row(make_row(32'hFFFF_FFFF, 1'b0));
      add_row(make_row(32'h5555_5555, 1'b0));
      add_row(make_row(32'hAAAA_AAAA, 1'b0));
      add_row(make_row(32'd10, 1'b1));
      add_row(make_row(32'd20, 1'b0));
      add_row(make_row(32'd15, 1'b0));   // tie when balanced
      add_row(make_row(32'd15, 1'b0));   // tie when upper is heavy
      add_row(make_row(32'd25, 1'b0));
      add_row(make_row(32'd7, 1'b1));
      add_row(make_row(32'd7, 1'b0));    // tie when lower is heavy
      add_row(make_row(32'd3, 1'b0));
      add_row(make_row(32'd7, 1'b0));
      add_row(make_row(32'd1, 1'b0));
      add_row(pinned_row(32'hFFFF_FFFE, 1'b1, 33'h1_FFFF_FFFC, 11'd1, 1'b0));
      add_row(make_row(32'hFFFF_FFFD, 1'b0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) send_beat(directed_rows[k]);

      // Stall the response side for a long stretch while beats keep coming.
      hold_rsp   = 1'b1;
      burst_left = 80;

      // Random runs: most start with a restart so the halves see short and long
      // histories; a few continue the previous run or restart mid-run.
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                : $urandom_range(3, 40);
         spread = spread_type'($urandom_range(0, 3));
         first  = ($urandom_range(0, 4) != 0);
         while (run_left > 0 && sent_random < RANDOM_ITEMS) begin
            send_beat(make_row(pick_sample(spread), first || ($urandom_range(0, 99) == 0)));
            first = 1'b0;
            run_left--;
            sent_random++;
         end
      end

      // Drain: wait for every median, then a few more cycles for strays.
      req_tvalid <= 1'b0;
      while (medians_checked < beats_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_medians.size() != 0)
         report_mismatch("medians never delivered", 64'(pending_medians.size()), '0);

      $display("Run covered %0d sample beats (%0d with restart), %0d medians checked,",
               beats_sent, restarts_sent, medians_checked);
      $display("  %0d samples dropped at full store, peak count held %0d.",
               drops_seen, peak_count);
      if (mismatch_count == 0) begin
         $display("** running_median_two_heaps_core: PASSED **");
      end else begin
         $display("** running_median_two_heaps_core: FAILED **");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready with pass runs, stalls and one long hold
   // ---------------------------------------------------------------------

   initial begin : rsp_side
      int unsigned pass_left;
      int unsigned stall_left;
      rsp_tready = 1'b0;
      pass_left  = 0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp   = 1'b0;
            pass_left  = 0;
            stall_left = LONG_HOLD;
         end
         if (pass_left > 0) begin
            rsp_tready <= 1'b1;
            pass_left--;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            pass_left  = pick_pass() - 1;
            stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on each accepted request beat, check each response beat
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : watch
      beat_row_type      row;
      median_result_type calc;
      median_result_type want;
      if (!reset) begin
         if (req_tvalid === 1'b1 && req_tready === 1'b1) begin
            row  = offered_rows.pop_front();
            calc = track_median(req_tdata, req_tuser);
            // pinned rows carry a hand-typed result; the predictor still advances
            if (row.pinned) begin
               calc.median_x2 = row.med;
               calc.count     = row.cnt;
               calc.dropped   = row.drop;
            end
            pending_medians.insert(pending_medians.size(), calc);
         end
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
            if (pending_medians.size() == 0) begin
               report_mismatch("response beat with nothing expected", 64'(rsp_tdata), '0);
            end else begin
               want = pending_medians.pop_front();
               if (rsp_tdata[32:0] !== want.median_x2)
                  report_mismatch("median_doubled", 64'(rsp_tdata[32:0]), 64'(want.median_x2));
               if (rsp_tdata[43:33] !== want.count)
                  report_mismatch("sample_count", 64'(rsp_tdata[43:33]), 64'(want.count));
               if (rsp_tuser !== want.dropped)
                  report_mismatch("dropped", 64'(rsp_tuser), 64'(want.dropped));
               if (want.dropped) drops_seen++;
               if (want.count > peak_count) peak_count = want.count;
            end
            medians_checked++;
         end
      end
   end

   // Abort a hung run.
   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clock);
      $display("Timeout after %0d cycles, %0d medians still pending",
               cycles, pending_medians.size());
      $display("** running_median_two_heaps_core: FAILED **");
      $finish;
   end

endmodule
